// ===== sv/htg_pkg.sv =====
// ----------------------------------------------------------------------------
// htg_pkg: shared types and constants of the harmonic tone generator
// Register indexes, waveform codes and the fixed field widths of the
// configuration and sample channels.
// ----------------------------------------------------------------------------
package htg_pkg;

  // Configuration channel
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 48;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PHASE_STEP   = 3'd0,
    REG_WAVEFORM     = 3'd1,
    REG_AMPLITUDES   = 3'd2,
    REG_LEFT_PHASES  = 3'd3,
    REG_RIGHT_PHASES = 3'd4,
    REG_OUT_GAIN     = 3'd5
  } reg_index_t;

  // Register widths
  localparam int STEP_W  = 32;
  localparam int WSEL_W  = 2;
  localparam int AMP_W   = 8;
  localparam int OFS_W   = 16;
  localparam int GAIN_W  = 15;
  localparam int FIELDS  = 3;  // amplitude / offset fields held by the registers

  // Waveform codes
  localparam logic [WSEL_W-1:0] WAVE_SINE     = 2'd0;
  localparam logic [WSEL_W-1:0] WAVE_SQUARE   = 2'd1;
  localparam logic [WSEL_W-1:0] WAVE_TRIANGLE = 2'd2;

  // Register reset values
  localparam logic [STEP_W-1:0]       STEP_RESET  = 32'd42852281;
  localparam logic [WSEL_W-1:0]       WSEL_RESET  = WAVE_SINE;
  localparam logic [FIELDS*AMP_W-1:0] AMP_RESET   = 24'h010101;
  localparam logic [GAIN_W-1:0]       GAIN_RESET  = 15'd10000;

  // Waveform magnitude and sample formats
  localparam int WAVE_W      = 15;
  localparam int FULL_SCALE  = 32767;
  localparam int SAMPLE_W    = 16;

endpackage

// ===== sv/htg_channels.sv =====
// ----------------------------------------------------------------------------
// htg channels: valid/ready interfaces of the harmonic tone generator
// Trigger channel (one transaction per sample), sample channel and
// configuration write channel.
// ----------------------------------------------------------------------------
interface htg_trigger_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface htg_sample_if
  import htg_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_sample;
  logic signed [SAMPLE_W-1:0] right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink (input valid, input left_sample, input right_sample, output ready);
endinterface

interface htg_cfg_if
  import htg_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/htg_quarter_rom.sv =====
// ----------------------------------------------------------------------------
// htg_quarter_rom: quarter-wave sine table with registered read
// Entry k is round(32767*sin(pi/2*k/DEPTH)) from a Q30 Taylor series,
// built at elaboration.
// ----------------------------------------------------------------------------
module htg_quarter_rom
  import htg_pkg::*;
#(
  parameter int DEPTH = 1024,
  localparam int ADDR_W = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic [ADDR_W-1:0] addr,
  output logic [WAVE_W-1:0] data
);

  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic [WAVE_W-1:0] rom_t [0:DEPTH];

  function automatic rom_t build_rom();
    rom_t        tbl;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] r;
    logic [63:0] s;
    logic [63:0] v;
    for (int k = 0; k <= DEPTH; k++) begin
      x  = (64'(k) * HALF_PI_Q30) / 64'(DEPTH);
      x2 = (x * x) >> 30;
      // Horner evaluation of sin(x)/x up to the x^12 term
      r  = Q30_ONE;
      r  = Q30_ONE - ((x2 * r) >> 30) / 64'd156;
      r  = Q30_ONE - ((x2 * r) >> 30) / 64'd110;
      r  = Q30_ONE - ((x2 * r) >> 30) / 64'd72;
      r  = Q30_ONE - ((x2 * r) >> 30) / 64'd42;
      r  = Q30_ONE - ((x2 * r) >> 30) / 64'd20;
      r  = Q30_ONE - ((x2 * r) >> 30) / 64'd6;
      s  = (x * r) >> 30;
      v  = (s * 64'(FULL_SCALE) + (64'd1 << 29)) >> 30;
      if (v > 64'(FULL_SCALE)) begin
        v = 64'(FULL_SCALE);
      end
      tbl[k] = v[WAVE_W-1:0];
    end
    return tbl;
  endfunction

  localparam rom_t QTBL = build_rom();

  always_ff @(posedge clk) begin
    data <= QTBL[addr];
  end

endmodule

// ===== sv/harmonic_tone_generator_top.sv =====
// ----------------------------------------------------------------------------
// Sequencing: a trigger is taken only in the idle state, after the sample
// pair of the last one is loaded into the output register; the done state
// waits while that register is full and the sample channel stalls.
// Each of the 2*HARMONICS terms makes two passes through one shared
// multiplier and a divide-by-32767 estimate and correction.
// Reset: synchronous; registers return to their reset values, the phase
// accumulator clears, no clearing pass.
// ----------------------------------------------------------------------------
// harmonic_tone_generator_top: additive-synthesis stereo tone generator
// Phase accumulator, quarter-wave sine / square / triangle shaping and a
// sequenced multiply, scale and accumulate over all harmonic terms.
// ----------------------------------------------------------------------------
module harmonic_tone_generator_top
  import htg_pkg::*;
#(
  parameter int HARMONICS        = 3,
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int PHASE_BITS       = 32
) (
  input  logic         clk,
  input  logic         rst,
  htg_trigger_if.sink  trigger,
  htg_sample_if.source sample,
  htg_cfg_if.sink      cfg
);

  localparam int QBITS  = PHASE_BITS - 2;
  localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int IDXP_W = QBITS + IDX_W;
  localparam int TRI_W  = QBITS + WAVE_W;
  localparam int H_W    = (HARMONICS > 1) ? $clog2(HARMONICS) : 1;
  localparam int MA_W   = AMP_W + GAIN_W;          // amplitude * gain
  localparam int PROD_W = MA_W + WAVE_W;           // * waveform magnitude
  localparam int Q_W    = PROD_W - WAVE_W + 1;
  localparam int SUM_W  = Q_W + 2 + $clog2(HARMONICS);

  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(FULL_SCALE);
  localparam logic signed [SUM_W-1:0] SAT_MIN = ~SAT_MAX;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PHASE,
    S_LOOK,
    S_WAVE,
    S_MUL,
    S_DIV,
    S_CORR,
    S_DONE
  } state_t;

  // Configuration registers
  logic [STEP_W-1:0]       phase_step;
  logic [WSEL_W-1:0]       waveform;
  logic [FIELDS*AMP_W-1:0] amplitudes;
  logic [FIELDS*OFS_W-1:0] left_phases;
  logic [FIELDS*OFS_W-1:0] right_phases;
  logic [GAIN_W-1:0]       out_gain;

  // Sequencer and datapath registers
  state_t                   state;
  logic [PHASE_BITS-1:0]    acc;
  logic [PHASE_BITS-1:0]    cur;
  logic [PHASE_BITS-1:0]    base;
  logic [PHASE_BITS-1:0]    p;
  logic [H_W-1:0]           h;
  logic                     ch;
  logic [WAVE_W-1:0]        mag;
  logic                     neg;
  logic [PROD_W-1:0]        prod;
  logic [Q_W-1:0]           q0;
  logic signed [SUM_W-1:0]  sum_l;
  logic signed [SUM_W-1:0]  sum_r;
  logic                     out_valid;
  logic [SAMPLE_W-1:0]      left_q;
  logic [SAMPLE_W-1:0]      right_q;

  // Combinational datapath
  logic [AMP_W-1:0]         amp_sel;
  logic [OFS_W-1:0]         ofs_sel;
  logic [1:0]               quad;
  logic [QBITS-1:0]         frac;
  logic [IDXP_W-1:0]        idx_prod;
  logic [IDX_W-1:0]         idx;
  logic [IDX_W-1:0]         rom_addr;
  logic [WAVE_W-1:0]        rom_data;
  logic [TRI_W-1:0]         tri_prod;
  logic [WAVE_W-1:0]        tri_val;
  logic [WAVE_W-1:0]        mag_next;
  logic                     neg_next;
  logic [MA_W-1:0]          mul_a;
  logic [WAVE_W-1:0]        mul_b;
  logic [PROD_W-1:0]        mul_p;
  logic [PROD_W:0]          q_est;
  logic [PROD_W:0]          rem;
  logic [Q_W-1:0]           q_fix;
  logic signed [SUM_W-1:0]  term_s;
  logic                     last_term;

  assign trigger.ready       = (state == S_IDLE);
  assign cfg.ready           = 1'b1;
  assign sample.valid        = out_valid;
  assign sample.left_sample  = left_q;
  assign sample.right_sample = right_q;

  // Field selection for the current harmonic; harmonics past the register
  // fields get zero amplitude and zero offset.
  always_comb begin
    amp_sel = '0;
    ofs_sel = '0;
    for (int i = 0; i < FIELDS; i++) begin
      if (32'(h) == i) begin
        amp_sel = amplitudes[AMP_W*i +: AMP_W];
        ofs_sel = ch ? right_phases[OFS_W*i +: OFS_W] : left_phases[OFS_W*i +: OFS_W];
      end
    end
  end

  assign quad     = p[PHASE_BITS-1 -: 2];
  assign frac     = p[QBITS-1:0];
  assign idx_prod = IDXP_W'(frac) * IDXP_W'(SINE_TABLE_DEPTH);
  assign idx      = IDX_W'(idx_prod >> QBITS);
  assign rom_addr = quad[0] ? IDX_W'(SINE_TABLE_DEPTH) - idx : idx;

  htg_quarter_rom #(
    .DEPTH (SINE_TABLE_DEPTH)
  ) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  assign tri_prod = (TRI_W'(frac) << WAVE_W) - TRI_W'(frac);
  assign tri_val  = WAVE_W'(tri_prod >> QBITS);

  always_comb begin
    neg_next = quad[1];
    unique case (waveform)
      WAVE_SINE: begin
        mag_next = rom_data;
      end
      WAVE_SQUARE: begin
        // zero exactly at the zero crossings
        mag_next = (frac == '0 && !quad[0]) ? '0 : WAVE_W'(FULL_SCALE);
      end
      WAVE_TRIANGLE: begin
        mag_next = quad[0] ? WAVE_W'(FULL_SCALE) - tri_val : tri_val;
      end
      default: begin
        mag_next = '0;
      end
    endcase
  end

  // Shared multiplier: amplitude * gain, then that product * magnitude
  assign mul_a = (state == S_LOOK) ? MA_W'(amp_sel) : prod[MA_W-1:0];
  assign mul_b = (state == S_LOOK) ? WAVE_W'(out_gain) : mag;
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Divide by 2^15-1: series estimate, then one correction step
  assign q_est  = ((PROD_W+1)'(prod) + (PROD_W+1)'(prod >> 15) + (PROD_W+1)'(prod >> 30)) >> 15;
  assign rem    = (PROD_W+1)'(prod) - ((PROD_W+1)'(q0) << 15) + (PROD_W+1)'(q0);
  assign q_fix  = (rem >= (PROD_W+1)'(FULL_SCALE)) ? q0 + Q_W'(1) : q0;
  assign term_s = signed'(SUM_W'(q_fix));

  assign last_term = ch && (h == H_W'(HARMONICS - 1));

  function automatic logic [SAMPLE_W-1:0] saturate(logic signed [SUM_W-1:0] s);
    logic [SAMPLE_W-1:0] r;
    if (s > SAT_MAX) begin
      r = SAMPLE_W'(SAT_MAX);
    end else if (s < SAT_MIN) begin
      r = SAMPLE_W'(SAT_MIN);
    end else begin
      r = s[SAMPLE_W-1:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step   <= STEP_RESET;
      waveform     <= WSEL_RESET;
      amplitudes   <= AMP_RESET;
      left_phases  <= '0;
      right_phases <= '0;
      out_gain     <= GAIN_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_PHASE_STEP:   phase_step   <= cfg.data[STEP_W-1:0];
        REG_WAVEFORM:     waveform     <= cfg.data[WSEL_W-1:0];
        REG_AMPLITUDES:   amplitudes   <= cfg.data[FIELDS*AMP_W-1:0];
        REG_LEFT_PHASES:  left_phases  <= cfg.data[FIELDS*OFS_W-1:0];
        REG_RIGHT_PHASES: right_phases <= cfg.data[FIELDS*OFS_W-1:0];
        REG_OUT_GAIN:     out_gain     <= cfg.data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      acc       <= '0;
      out_valid <= 1'b0;
      h         <= '0;
      ch        <= 1'b0;
    end else begin
      // the done state reloads the output register itself
      if (sample.valid && sample.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (trigger.valid) begin
            // restart clears the phase before this sample
            cur   <= trigger.restart ? '0 : acc;
            base  <= trigger.restart ? '0 : acc;
            acc   <= (trigger.restart ? '0 : acc) + PHASE_BITS'(phase_step);
            h     <= '0;
            ch    <= 1'b0;
            sum_l <= '0;
            sum_r <= '0;
            state <= S_PHASE;
          end
        end
        S_PHASE: begin
          p     <= base + (PHASE_BITS'(ofs_sel) << (PHASE_BITS - OFS_W));
          state <= S_LOOK;
        end
        S_LOOK: begin
          prod  <= mul_p;
          state <= S_WAVE;
        end
        S_WAVE: begin
          mag   <= mag_next;
          neg   <= neg_next;
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= mul_p;
          state <= S_DIV;
        end
        S_DIV: begin
          q0    <= Q_W'(q_est);
          state <= S_CORR;
        end
        S_CORR: begin
          if (ch) begin
            sum_r <= neg ? sum_r - term_s : sum_r + term_s;
          end else begin
            sum_l <= neg ? sum_l - term_s : sum_l + term_s;
          end
          if (last_term) begin
            state <= S_DONE;
          end else begin
            if (ch) begin
              h    <= h + H_W'(1);
              base <= base + cur;
            end
            ch    <= ~ch;
            state <= S_PHASE;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid || sample.ready) begin
            left_q    <= saturate(sum_l);
            right_q   <= saturate(sum_r);
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
